FILE: hdl/kvlf_pkg.sv
// ============================================================================
// kvlf_pkg: shared definitions for the key/value line finder
// Character codes, register indexes, parse phases and the configuration
// bundle that the register block hands to the parser.
// ============================================================================
package kvlf_pkg;

    // Widths fixed by the interface.
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int KEY_LEN_W   = 5;
    localparam int KEY_IDX_W   = 4;
    localparam int RESULT_W    = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_KEY_BYTES = 16;
    localparam int DEF_OFFSET_BITS   = 16;

    // Register indexes (byte address / 8).
    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_NAME   = 3'd1,
        PH_EQUALS = 3'd2,
        PH_VALUE  = 3'd3,
        PH_CLOSE  = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    // Outcome of one byte.
    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_MISS = 2'd1,
        DEC_HIT  = 2'd2
    } decide_t;

    // Configuration seen by the parser.
    typedef struct packed {
        logic [DATA_W-1:0]    key_low;
        logic [DATA_W-1:0]    key_high;
        logic [KEY_LEN_W-1:0] key_len;
    } cfg_t;

endpackage

FILE: hdl/key_value_line_finder_top.sv
// ============================================================================
// key_value_line_finder_top: key/value line finder
// Scans a byte stream for a configured key followed by '=' and reports the
// offset and length of the value, one result per buffer.
// ============================================================================
//
//   Channel   Direction  Ports                                  Moves
//   s_        in         s_valid/s_ready, s_text_byte,          one buffer byte
//                        s_last_byte
//   m_        out        m_valid/m_ready, m_found,              one result per buffer
//                        m_value_start, m_value_length
//   APB       in/out     psel, penable, pwrite, paddr, pwdata,  register access
//                        prdata, pready
//
// One byte per cycle is sustained while m_ is not stalled; the parse step is
// a single pass of logic between the input register and the result register.
// A byte passes through the input register and then the result register.
// Reset (aresetn low, synchronous) clears the key registers, valid flags and scan state.
// A stall on m_ holds the result; input transfers continue until the input
// register is full behind it.
// ============================================================================
module key_value_line_finder_top #(
    parameter int MAX_KEY_BYTES = kvlf_pkg::DEF_MAX_KEY_BYTES,
    parameter int OFFSET_BITS   = kvlf_pkg::DEF_OFFSET_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kvlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [kvlf_pkg::DATA_W-1:0]   pwdata,
    output logic [kvlf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Byte input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_text_byte,
    input  logic                          s_last_byte,
    // Result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [kvlf_pkg::RESULT_W-1:0] m_value_start,
    output logic [kvlf_pkg::RESULT_W-1:0] m_value_length
);
    import kvlf_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       parse_ready;

    // Configuration registers.
    kvlf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: refills in the cycle the parser takes its byte.
    assign s_ready       = !in_valid_reg || parse_ready;
    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !parse_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Parse step and result register.
    kvlf_parser #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (in_valid_reg),
        .in_ready   (parse_ready),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res_found  (m_found),
        .res_start  (m_value_start),
        .res_length (m_value_length)
    );

    // A not-found result carries zero offset and length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_value_start == '0 && m_value_length == '0)
        else $error("not-found result with nonzero payload");

    // A found value always holds at least one byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_value_length != '0)
        else $error("found result with empty value");

    // A new result only appears after a byte sat in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result without a byte to decide it");

endmodule

FILE: hdl/kvlf_regs.sv
// ============================================================================
// kvlf_regs: configuration register block
// APB-style write/read port holding the key bytes and the key length.
// ============================================================================
module kvlf_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kvlf_pkg::ADDR_W-1:0] paddr,
    input  logic [kvlf_pkg::DATA_W-1:0] pwdata,
    output logic [kvlf_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output kvlf_pkg::cfg_t              cfg
);
    import kvlf_pkg::*;

    logic [DATA_W-1:0]    key_low_reg;
    logic [DATA_W-1:0]    key_high_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [1:0]           reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    // Register writes at the access cycle of a write transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_KEY_LOW:  key_low_reg  <= pwdata;
                REG_KEY_HIGH: key_high_reg <= pwdata;
                REG_KEY_LEN:  key_len_reg  <= pwdata[KEY_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LEN:  prdata = {{(DATA_W-KEY_LEN_W){1'b0}}, key_len_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.key_low  = key_low_reg;
    assign cfg.key_high = key_high_reg;
    assign cfg.key_len  = key_len_reg;

endmodule

FILE: hdl/kvlf_parser.sv
// ============================================================================
// kvlf_parser: per-byte parse step and result register
// Updates the scan state for one byte per cycle unless a held result stalls
// it; loads a result into the output register when a byte decides the buffer.
// ============================================================================
module kvlf_parser #(
    parameter int MAX_KEY_BYTES = kvlf_pkg::DEF_MAX_KEY_BYTES,
    parameter int OFFSET_BITS   = kvlf_pkg::DEF_OFFSET_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kvlf_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          res_found,
    output logic [kvlf_pkg::RESULT_W-1:0] res_start,
    output logic [kvlf_pkg::RESULT_W-1:0] res_length
);
    import kvlf_pkg::*;

    localparam int KP_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int CNT_W = (OFFSET_BITS < RESULT_W) ? OFFSET_BITS : RESULT_W;

    // Scan state.
    phase_t           phase_reg,      phase_next;
    logic [KP_W-1:0]  key_pos_reg,    key_pos_next;
    logic [CNT_W-1:0] byte_off_reg,   byte_off_next;
    logic [CNT_W-1:0] start_off_reg,  start_off_next;
    logic [CNT_W-1:0] run_len_reg,    run_len_next;

    // Result register.
    logic                res_valid_reg,  res_valid_next;
    logic                res_found_reg,  res_found_next;
    logic [RESULT_W-1:0] res_start_reg,  res_start_next;
    logic [RESULT_W-1:0] res_length_reg, res_length_next;

    logic                   take;
    logic [KP_W-1:0]        klen;
    logic [2*DATA_W-1:0]    key_vec;
    logic [KEY_IDX_W-1:0]   key_idx;
    logic [7:0]             key_char;
    logic [7:0]             folded;
    logic                   printable;
    logic                   key_hit;
    decide_t                decision;

    assign in_ready = !res_valid_reg || res_ready;
    assign take     = in_valid && in_ready;

    // Key length clamp and key byte selection.
    assign klen      = (cfg.key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                       KP_W'(MAX_KEY_BYTES) : KP_W'(cfg.key_len);
    assign key_vec   = {cfg.key_high, cfg.key_low};
    assign key_idx   = KEY_IDX_W'(key_pos_reg);
    assign key_char  = key_vec[key_idx*8 +: 8];
    assign folded    = in_byte | CASE_BIT;
    assign key_hit   = folded == (key_char | CASE_BIT);
    assign printable = in_byte inside {[CH_SPACE:CH_TILDE]};

    // Next state and result for one byte.
    always_comb begin
        phase_next      = phase_reg;
        key_pos_next    = key_pos_reg;
        byte_off_next   = byte_off_reg;
        start_off_next  = start_off_reg;
        run_len_next    = run_len_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_found_next  = res_found_reg;
        res_start_next  = res_start_reg;
        res_length_next = res_length_reg;
        decision        = DEC_NONE;

        if (take) begin
            if (phase_reg == PH_SKIP) begin
                // Drop bytes until the end of the buffer.
                if (in_last) begin
                    phase_next     = PH_SEARCH;
                    key_pos_next   = '0;
                    byte_off_next  = '0;
                    start_off_next = '0;
                    run_len_next   = '0;
                end
            end else begin
                byte_off_next = (byte_off_reg == '1) ? byte_off_reg
                                                     : byte_off_reg + 1'b1;
                case (phase_reg)
                    PH_SEARCH: begin
                        if (klen == '0) begin
                            decision = DEC_MISS;
                        end else if (key_hit) begin
                            key_pos_next = KP_W'(1);
                            phase_next   = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (key_pos_reg < klen && key_hit) begin
                            key_pos_next = key_pos_reg + 1'b1;
                        end else if (in_byte == CH_EQUALS && key_pos_reg == klen) begin
                            phase_next = PH_EQUALS;
                        end else begin
                            key_pos_next = '0;
                            phase_next   = PH_SEARCH;
                        end
                    end
                    PH_EQUALS: begin
                        // Leading quotes are skipped; the first printable byte
                        // opens the value.
                        if (in_byte == CH_QUOTE) begin
                            phase_next = PH_EQUALS;
                        end else if (printable) begin
                            start_off_next = byte_off_reg;
                            run_len_next   = CNT_W'(1);
                            phase_next     = PH_VALUE;
                        end else begin
                            decision = DEC_MISS;
                        end
                    end
                    PH_VALUE: begin
                        if (in_byte == CH_QUOTE) begin
                            phase_next = PH_CLOSE;
                        end else if (in_byte == CH_NEWLINE) begin
                            decision = DEC_HIT;
                        end else if (printable) begin
                            run_len_next = (run_len_reg == '1) ? run_len_reg
                                                               : run_len_reg + 1'b1;
                        end else begin
                            decision = DEC_MISS;
                        end
                    end
                    default: begin
                        // Closing quote must be followed by a newline.
                        decision = (phase_reg == PH_CLOSE && in_byte == CH_NEWLINE) ?
                                   DEC_HIT : DEC_MISS;
                    end
                endcase

                // Load a result when the byte decides or the buffer ends.
                if (decision != DEC_NONE || in_last) begin
                    res_valid_next = 1'b1;
                    if (decision == DEC_HIT) begin
                        res_found_next  = 1'b1;
                        res_start_next  = RESULT_W'(start_off_reg);
                        res_length_next = RESULT_W'(run_len_reg);
                    end else begin
                        res_found_next  = 1'b0;
                        res_start_next  = '0;
                        res_length_next = '0;
                    end
                    if (in_last) begin
                        phase_next     = PH_SEARCH;
                        key_pos_next   = '0;
                        byte_off_next  = '0;
                        start_off_next = '0;
                        run_len_next   = '0;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEARCH;
            key_pos_reg   <= '0;
            byte_off_reg  <= '0;
            start_off_reg <= '0;
            run_len_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            key_pos_reg   <= key_pos_next;
            byte_off_reg  <= byte_off_next;
            start_off_reg <= start_off_next;
            run_len_reg   <= run_len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        res_found_reg  <= res_found_next;
        res_start_reg  <= res_start_next;
        res_length_reg <= res_length_next;
    end

    assign res_valid  = res_valid_reg;
    assign res_found  = res_found_reg;
    assign res_start  = res_start_reg;
    assign res_length = res_length_reg;

endmodule
